### rtl/core/esym_pkg.sv
`timescale 1ns / 1ps
// shared constants for the 2x2 symmetric eigen solver
// no dependencies

package esym_pkg;

  localparam int IN_WIDTH_DEF      = 16;
  localparam int VEC_FRAC_BITS_DEF = 14;
  // extra fraction bits carried through the root and eigenvalue math
  localparam int GUARD_BITS        = 28;

endpackage

### rtl/core/esym_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the eigen solver: matrix words in, result words out
// depends on esym_pkg

interface esym_mat_if
  import esym_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] diag_first;
  logic signed [IN_WIDTH-1:0] off_diag;
  logic signed [IN_WIDTH-1:0] diag_second;

  modport source (output valid, diag_first, off_diag, diag_second, input ready);
  modport sink   (input valid, diag_first, off_diag, diag_second, output ready);
endinterface

interface esym_res_if
  import esym_pkg::*;
#(
  parameter int IN_WIDTH      = IN_WIDTH_DEF,
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic signed [IN_WIDTH+1:0]      eig_small;
  logic signed [IN_WIDTH+1:0]      eig_large;
  logic signed [VEC_FRAC_BITS+1:0] vec_x;
  logic signed [VEC_FRAC_BITS+1:0] vec_y;

  modport source (output valid, eig_small, eig_large, vec_x, vec_y, input ready);
  modport sink   (input valid, eig_small, eig_large, vec_x, vec_y, output ready);
endinterface

### rtl/core/esym_sqrt.sv
`timescale 1ns / 1ps
// pipelined square root, one result bit per stage, rounded to nearest (ties up)
// no dependencies; side data travels alongside the radicand

module esym_sqrt #(
  parameter int RW     = 90,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RW/2:0]     root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int NI  = RW / 2;
  localparam int RMW = NI + 4;

  logic              vld   [NI];
  logic [RW-1:0]     rads  [NI];
  logic [RMW-1:0]    rems  [NI];
  logic [NI-1:0]     roots [NI];
  logic [SIDE_W-1:0] sides [NI];

  for (genvar i = 0; i < NI; i++) begin : g_step
    logic              v_i;
    logic [RW-1:0]     rad_i;
    logic [RMW-1:0]    rem_i;
    logic [NI-1:0]     root_i;
    logic [SIDE_W-1:0] side_i;
    logic [RMW-1:0]    cur;
    logic [RMW-1:0]    trial;
    logic              take;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_rest
      assign v_i    = vld[i-1];
      assign rad_i  = rads[i-1];
      assign rem_i  = rems[i-1];
      assign root_i = roots[i-1];
      assign side_i = sides[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cur   = {rem_i[RMW-3:0], rad_i[RW-1:RW-2]};
    assign trial = RMW'({root_i, 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rads[i]  <= rad_i << 2;
        rems[i]  <= take ? cur - trial : cur;
        roots[i] <= {root_i[NI-2:0], take};
        sides[i] <= side_i;
      end
    end
  end

  // remainder above the floor root means the true root is past the half point
  logic round_up;
  assign round_up = rems[NI-1] > RMW'(roots[NI-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NI-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root     <= (NI+1)'(roots[NI-1]) + (NI+1)'(round_up);
      side_out <= sides[NI-1];
    end
  end

endmodule

### rtl/core/esym_div.sv
`timescale 1ns / 1ps
// two-lane pipelined fraction divider sharing one denominator
// result is round(num * 2^FB / den) capped at 1.0; depends on esym_pkg

module esym_div
  import esym_pkg::*;
#(
  parameter int DW     = 48,
  parameter int FB     = VEC_FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     num_x,
  input  logic [DW-1:0]     num_y,
  input  logic [DW-1:0]     den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [FB:0]       q_x,
  output logic [FB:0]       q_y,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic [FB+1:0] ONE = (FB+2)'(1) << FB;

  logic              vld   [FB+1];
  logic [DW-1:0]     dens  [FB+1];
  logic [SIDE_W-1:0] sides [FB+1];
  logic [DW-1:0]     rems  [FB+1][2];
  logic [FB:0]       quos  [FB+1][2];
  logic              bigs  [FB+1][2];
  logic [DW-1:0]     nums  [2];
  logic [FB:0]       fin   [2];

  assign nums[0] = num_x;
  assign nums[1] = num_y;

  // integer step: quotient of two or more saturates straight to one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens[0]  <= den;
      sides[0] <= side_in;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane0
    logic ge;
    assign ge = nums[l] >= den;
    always_ff @(posedge clk) begin
      if (en) begin
        bigs[0][l] <= {1'b0, nums[l]} >= {den, 1'b0};
        quos[0][l] <= (FB+1)'(ge);
        rems[0][l] <= ge ? nums[l] - den : nums[l];
      end
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dens[k]  <= dens[k-1];
        sides[k] <= sides[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] r2;
      logic        take;
      assign r2   = {rems[k-1][l], 1'b0};
      assign take = r2 >= {1'b0, dens[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rems[k][l] <= take ? DW'(r2 - {1'b0, dens[k-1]}) : DW'(r2);
          quos[k][l] <= {quos[k-1][l][FB-1:0], take};
          bigs[k][l] <= bigs[k-1][l];
        end
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_round
    logic          up;
    logic [FB+1:0] qr;
    assign up     = {rems[FB][l], 1'b0} >= {1'b0, dens[FB]};
    assign qr     = {1'b0, quos[FB][l]} + (FB+2)'(up);
    assign fin[l] = (bigs[FB][l] || qr > ONE) ? ONE[FB:0] : qr[FB:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x      <= fin[0];
      q_y      <= fin[1];
      side_out <= sides[FB];
    end
  end

endmodule

### rtl/core/symmetric_2x2_eigen_solver.sv
`timescale 1ns / 1ps
// pipeline depth is mostly set by the two bit-per-stage square roots and the bit-per-stage
// vector divider
// throughput: one matrix word per cycle while the output is not stalled, one result word per matrix
// a stalled output freezes the pipe; the first stage still fills an empty slot
// rst is synchronous and clears all valid bits; data registers are not reset

module symmetric_2x2_eigen_solver
  import esym_pkg::*;
#(
  parameter int IN_WIDTH      = IN_WIDTH_DEF,
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  esym_mat_if.sink    mat,
  esym_res_if.source  res
);

  localparam int W   = IN_WIDTH;
  localparam int G   = GUARD_BITS;
  localparam int F   = VEC_FRAC_BITS;
  localparam int EW  = W + 2;
  localparam int VW  = F + 2;
  localparam int XW  = 2 * W + 2;
  localparam int RW1 = XW + 2 * G;
  localparam int SW  = RW1 / 2 + 1;
  localparam int TW  = W + 32;
  localparam int H   = (SW + 1) / 2;
  localparam int HW  = SW - H;
  localparam int RW2 = 2 * SW + 2;
  localparam int NW  = RW2 / 2 + 1;

  localparam logic signed [TW-1:0] HALF_LSB = TW'(1) << G;
  localparam logic signed [TW-1:0] EIG_MAX  = {{(TW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [TW-1:0] EIG_MIN  = ~EIG_MAX;
  localparam logic signed [VW-1:0] VEC_ONE  = VW'(1) << F;

  typedef struct packed {
    logic signed [W-1:0] a;
    logic signed [W-1:0] d;
    logic signed [W:0]   sum;
    logic signed [W:0]   diff;
    logic [W-1:0]        absb;
    logic                bz;
    logic                altd;
    logic                bpos;
  } mat_info_t;

  typedef struct packed {
    mat_info_t    info;
    logic [2*W-1:0] bsq;
  } sq1_side_t;

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  d;
    logic signed [EW-1:0] e1;
    logic signed [EW-1:0] e2;
    logic                 bz;
    logic                 altd;
    logic                 bpos;
  } fin_t;

  typedef struct packed {
    fin_t          fin;
    logic [SW-1:0] u;
    logic [SW-1:0] bg;
  } sq2_side_t;

  function automatic logic signed [EW-1:0] sat_eig(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] q;
    q = t >>> (G + 1);
    if (q > EIG_MAX) begin
      q = EIG_MAX;
    end else if (q < EIG_MIN) begin
      q = EIG_MIN;
    end
    return EW'(q);
  endfunction

  logic adv;
  logic out_v;

  assign adv       = !out_v || res.ready;

  // stage 1: decode the matrix word
  logic            v1;
  mat_info_t       info1;
  logic [W:0]      absd1;
  logic signed [W:0] a_x, d_x, diff_c;

  assign mat.ready = adv || !v1;
  assign a_x       = {mat.diag_first[W-1], mat.diag_first};
  assign d_x       = {mat.diag_second[W-1], mat.diag_second};
  assign diff_c    = a_x - d_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (mat.ready) begin
      v1 <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mat.ready) begin
      info1.a    <= mat.diag_first;
      info1.d    <= mat.diag_second;
      info1.sum  <= a_x + d_x;
      info1.diff <= diff_c;
      info1.absb <= mat.off_diag[W-1] ? W'(-mat.off_diag) : W'(mat.off_diag);
      info1.bz   <= mat.off_diag == '0;
      info1.altd <= mat.diag_first < mat.diag_second;
      info1.bpos <= !mat.off_diag[W-1] && (mat.off_diag != '0);
      absd1      <= diff_c[W] ? (W+1)'(-diff_c) : (W+1)'(diff_c);
    end
  end

  // stage 2: (a-d)^2
  logic            v2;
  mat_info_t       info2;
  logic [XW-1:0]   dsq_c, dsq2;

  assign dsq_c = absd1 * absd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info2 <= info1;
      dsq2  <= dsq_c;
    end
  end

  // stage 3: (a-d)^2 + 4 b^2
  logic            v3;
  mat_info_t       info3;
  logic [2*W-1:0]  bsq_c, bsq3;
  logic [XW-1:0]   x3;

  assign bsq_c = info2.absb * info2.absb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info3 <= info2;
      bsq3  <= bsq_c;
      x3    <= dsq2 + (XW'(bsq_c) << 2);
    end
  end

  // first root: S = sqrt(x) scaled by 2^G
  sq1_side_t sq1_i, sq1_o;
  logic [SW-1:0] s_root;
  logic          s_v;

  assign sq1_i.info = info3;
  assign sq1_i.bsq  = bsq3;

  esym_sqrt #(
    .RW     (RW1),
    .SIDE_W ($bits(sq1_side_t))
  ) u_root_s (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .rad       (RW1'(x3) << (2 * G)),
    .side_in   (sq1_i),
    .out_valid (s_v),
    .root      (s_root),
    .side_out  (sq1_o)
  );

  // stage 4: eigenvalues and the unnormalized vector
  logic signed [TW-1:0] sum_g, diff_g, s_g, u_t;
  logic            v4;
  fin_t            fin4;
  logic [SW-1:0]   u4, bg4;
  logic [2*W-1:0]  bsq4;

  assign sum_g  = TW'($signed(sq1_o.info.sum)) <<< G;
  assign diff_g = TW'($signed(sq1_o.info.diff)) <<< G;
  assign s_g    = $signed(TW'(s_root));
  assign u_t    = s_g - diff_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin4.a    <= sq1_o.info.a;
      fin4.d    <= sq1_o.info.d;
      fin4.e1   <= sat_eig(sum_g - s_g + HALF_LSB);
      fin4.e2   <= sat_eig(sum_g + s_g + HALF_LSB);
      fin4.bz   <= sq1_o.info.bz;
      fin4.altd <= sq1_o.info.altd;
      fin4.bpos <= sq1_o.info.bpos;
      u4        <= u_t[TW-1] ? '0 : SW'(u_t);
      bg4       <= SW'(sq1_o.info.absb) << (G + 1);
      bsq4      <= sq1_o.bsq;
    end
  end

  // stages 5 to 7: u^2 + b'^2 from half-width partial products
  logic            v5, v6, v7;
  fin_t            fin5, fin6, fin7;
  logic [SW-1:0]   u5, u6, u7, bg5, bg6, bg7;
  logic [RW2-1:0]  acc5, acc6, acc7;
  logic [2*H-1:0]  p_ll;
  logic [SW-1:0]   p_lh;
  logic [2*HW-1:0] p_hh;
  logic [H-1:0]    ul4, ul5;
  logic [HW-1:0]   uh5, uh6;

  assign ul4  = u4[H-1:0];
  assign ul5  = u5[H-1:0];
  assign uh5  = u5[SW-1:H];
  assign uh6  = u6[SW-1:H];
  assign p_ll = ul4 * ul4;
  assign p_lh = ul5 * uh5;
  assign p_hh = uh6 * uh6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin5 <= fin4;
      u5   <= u4;
      bg5  <= bg4;
      acc5 <= RW2'(p_ll) + (RW2'(bsq4) << (2 * G + 2));
      fin6 <= fin5;
      u6   <= u5;
      bg6  <= bg5;
      acc6 <= acc5 + (RW2'(p_lh) << (H + 1));
      fin7 <= fin6;
      u7   <= u6;
      bg7  <= bg6;
      acc7 <= acc6 + (RW2'(p_hh) << (2 * H));
    end
  end

  // second root: vector length
  sq2_side_t sq2_i, sq2_o;
  logic [NW-1:0] n_root;
  logic          n_v;

  assign sq2_i.fin = fin7;
  assign sq2_i.u   = u7;
  assign sq2_i.bg  = bg7;

  esym_sqrt #(
    .RW     (RW2),
    .SIDE_W ($bits(sq2_side_t))
  ) u_root_n (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v7),
    .rad       (acc7),
    .side_in   (sq2_i),
    .out_valid (n_v),
    .root      (n_root),
    .side_out  (sq2_o)
  );

  // normalize both components
  fin_t       fin_d;
  logic [F:0] qx, qy;
  logic       q_v;

  esym_div #(
    .DW     (NW),
    .FB     (F),
    .SIDE_W ($bits(fin_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (n_v),
    .num_x     (NW'(sq2_o.u)),
    .num_y     (NW'(sq2_o.bg)),
    .den       (n_root),
    .side_in   (sq2_o.fin),
    .out_valid (q_v),
    .q_x       (qx),
    .q_y       (qy),
    .side_out  (fin_d)
  );

  // output register: pick the diagonal case or the computed result
  logic signed [EW-1:0] out_small, out_large;
  logic signed [VW-1:0] out_x, out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin_d.bz) begin
        if (fin_d.altd) begin
          out_small <= EW'(fin_d.a);
          out_large <= EW'(fin_d.d);
          out_x     <= VEC_ONE;
          out_y     <= '0;
        end else begin
          out_small <= EW'(fin_d.d);
          out_large <= EW'(fin_d.a);
          out_x     <= '0;
          out_y     <= VEC_ONE;
        end
      end else begin
        out_small <= fin_d.e1;
        out_large <= fin_d.e2;
        out_x     <= fin_d.bpos ? -$signed(VW'(qx)) : $signed(VW'(qx));
        out_y     <= $signed(VW'(qy));
      end
    end
  end

  assign res.valid     = out_v;
  assign res.eig_small = out_small;
  assign res.eig_large = out_large;
  assign res.vec_x     = out_x;
  assign res.vec_y     = out_y;

  // input only backs up when the pipe is frozen by the consumer
  assert property (@(posedge clk) disable iff (rst)
    !mat.ready |-> (res.valid && !res.ready))
    else $error("input stalled without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.eig_small <= res.eig_large))
    else $error("eigenvalues out of order");

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.vec_y >= 0 && res.vec_y <= VEC_ONE))
    else $error("vector y component outside [0, 1]");

endmodule

### sim/symmetric_2x2_eigen_solver_test.sv
`timescale 1ns / 1ps
// self-checking bench for the 2x2 symmetric eigen solver: directed table, then random matrices
// depends on esym_pkg, esym_if and symmetric_2x2_eigen_solver

module symmetric_2x2_eigen_solver_test;
  import esym_pkg::*;

  localparam int IW    = IN_WIDTH_DEF;
  localparam int VF    = VEC_FRAC_BITS_DEF;
  localparam int EW    = IW + 2;
  localparam int VW    = VF + 2;
  localparam int G     = GUARD_BITS;
  localparam int LAT   = 2 * IW + VF + 72;
  localparam int N_RND = 600;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [IW-1:0] a;
    logic signed [IW-1:0] b;
    logic signed [IW-1:0] d;
  } matrix_t;

  typedef struct {
    logic signed [EW-1:0] small_ev;
    logic signed [EW-1:0] large_ev;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } eigen_t;

  typedef struct {
    matrix_t m;
    bit      typed;
    eigen_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  esym_mat_if #(.IN_WIDTH(IW)) mat ();
  esym_res_if #(.IN_WIDTH(IW), .VEC_FRAC_BITS(VF)) res ();

  symmetric_2x2_eigen_solver #(.IN_WIDTH(IW), .VEC_FRAC_BITS(VF)) i_dut (
    .clk(clk), .rst(rst), .mat(mat), .res(res)
  );

  eigen_t pending_eigs[$];
  int     err_cnt     = 0;
  int     words_in    = 0;
  int     words_out   = 0;
  int     cycle_cnt   = 0;
  logic   sink_hold   = 1'b0;
  bit     slow_sink   = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [127:0] root_nearest(logic [127:0] v);
    logic [127:0] r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= v) r = c;
    end
    if (v > r * r + r) r = r + 1;
    return r;
  endfunction

  // round(num * 2^VF / den), ties up, capped at one
  function automatic logic [127:0] unit_frac(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = ((num << (VF + 1)) + den) / (den << 1);
    if (q > (128'd1 << VF)) q = 128'd1 << VF;
    return q;
  endfunction

  function automatic logic signed [EW-1:0] sat_eig(longint v);
    longint hi, lo;
    hi = (longint'(1) << (EW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[EW-1:0];
  endfunction

  function automatic eigen_t solve_eigen(matrix_t m);
    eigen_t       r;
    longint       a, b, d, diff, sumg, s, u, scale, vx, vy;
    logic [127:0] dm, bm, sq, n;
    a = m.a;
    b = m.b;
    d = m.d;
    if (b == 0) begin
      if (a < d) begin
        r.small_ev = sat_eig(a); r.large_ev = sat_eig(d); vx = 1 << VF; vy = 0;
      end else begin
        r.small_ev = sat_eig(d); r.large_ev = sat_eig(a); vx = 0; vy = 1 << VF;
      end
    end else begin
      scale = longint'(1) << G;
      diff  = a - d;
      dm    = 128'(diff < 0 ? -diff : diff) << G;
      bm    = 128'(b < 0 ? -b : b) << (G + 1);
      sq    = root_nearest(dm * dm + bm * bm);
      s     = longint'(sq[63:0]);
      sumg  = (a + d) * scale;
      r.small_ev = sat_eig((sumg - s + scale) >>> (G + 1));
      r.large_ev = sat_eig((sumg + s + scale) >>> (G + 1));
      u = s - diff * scale;
      if (u < 0) u = 0;
      n  = root_nearest(128'(u) * 128'(u) + bm * bm);
      vx = longint'(unit_frac(128'(u), n));
      vy = longint'(unit_frac(bm, n));
      if (b > 0) vx = -vx;
    end
    r.vx = vx[VW-1:0];
    r.vy = vy[VW-1:0];
    return r;
  endfunction

  function automatic logic signed [IW-1:0] rand_entry();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(IW-1){1'b0}}};
      1: return {1'b0, {(IW-1){1'b1}}};
      2: return IW'($signed($urandom_range(0, 8)) - 4);
      default: return IW'($urandom);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.a = rand_entry();
    m.b = rand_entry();
    m.d = rand_entry();
    case ($urandom_range(0, 9))
      0, 1: m.b = '0;
      2: m.d = m.a;
      default: ;
    endcase
    return m;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 29) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic row_t mk_row(int a, int b, int d, bit typed,
                                  int se = 0, int le = 0, int x = 0, int y = 0);
    row_t t;
    t.m.a = IW'(a); t.m.b = IW'(b); t.m.d = IW'(d);
    t.typed = typed;
    t.r.small_ev = EW'(se); t.r.large_ev = EW'(le); t.r.vx = VW'(x); t.r.vy = VW'(y);
    return t;
  endfunction

  // hand one matrix word to the block and record what it must produce
  task automatic send_matrix(matrix_t m, bit typed, eigen_t want);
    int g;
    g = slow_sink ? 0 : gap_len();
    if (g > 0) begin
      mat.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    mat.valid       <= 1'b1;
    mat.diag_first  <= m.a;
    mat.off_diag    <= m.b;
    mat.diag_second <= m.d;
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
    pending_eigs.push_back(typed ? want : solve_eigen(m));
    words_in++;
  endtask

  // long sink hold-off so the pipe fills and back-pressures the input
  initial begin
    wait (words_in >= 60);
    @(posedge clk);
    slow_sink = 1'b1;
    sink_hold <= 1'b1;
    repeat (3 * LAT) @(posedge clk);
    sink_hold <= 1'b0;
    slow_sink = 1'b0;
  end

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        if (pending_eigs.size() == 0) begin
          $display("unexpected result word %0d", words_out);
          err_cnt++;
        end else begin
          eigen_t w;
          w = pending_eigs.pop_front();
          if (res.eig_small !== w.small_ev) flag_mismatch("eig_small", res.eig_small, w.small_ev);
          if (res.eig_large !== w.large_ev) flag_mismatch("eig_large", res.eig_large, w.large_ev);
          if (res.vec_x !== w.vx) flag_mismatch("vec_x", res.vec_x, w.vx);
          if (res.vec_y !== w.vy) flag_mismatch("vec_y", res.vec_y, w.vy);
        end
        words_out++;
      end
      if (sink_hold) res.ready <= 1'b0;
      else if ($urandom_range(0, 39) == 0) res.ready <= 1'b0;
      else if ($urandom_range(0, 5) == 0) res.ready <= 1'($urandom_range(0, 1));
      else res.ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    row_t   dir[$];
    eigen_t none;
    matrix_t m;
    int     wait_cnt;
    none = '{default: '0};
    mat.valid       <= 1'b0;
    mat.diag_first  <= '0;
    mat.off_diag    <= '0;
    mat.diag_second <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero off-diagonal cases, ties included, are simple enough to type in
    dir.push_back(mk_row(0, 0, 0, 1, 0, 0, 0, 16384));
    dir.push_back(mk_row(32767, 0, -32768, 1, -32768, 32767, 0, 16384));
    dir.push_back(mk_row(-32768, 0, 32767, 1, -32768, 32767, 16384, 0));
    dir.push_back(mk_row(1280, 0, 1280, 1, 1280, 1280, 0, 16384));
    dir.push_back(mk_row(-1, 0, 0, 1, -1, 0, 16384, 0));
    dir.push_back(mk_row(-32768, 0, -32768, 1, -32768, -32768, 0, 16384));
    dir.push_back(mk_row(32767, 0, 32767, 1, 32767, 32767, 0, 16384));
    dir.push_back(mk_row(0, 1, 0, 0));
    dir.push_back(mk_row(0, -1, 0, 0));
    dir.push_back(mk_row(0, 32767, 0, 0));
    dir.push_back(mk_row(0, -32768, 0, 0));
    dir.push_back(mk_row(32767, 32767, 32767, 0));
    dir.push_back(mk_row(-32768, -32768, -32768, 0));
    dir.push_back(mk_row(32767, -32768, -32768, 0));
    dir.push_back(mk_row(-32768, 32767, 32767, 0));
    dir.push_back(mk_row(32767, 1, -32768, 0));
    dir.push_back(mk_row(-32768, -1, 32767, 0));
    dir.push_back(mk_row(256, 256, 256, 0));
    dir.push_back(mk_row(512, -128, -512, 0));
    dir.push_back(mk_row(-700, 3, 900, 0));
    dir.push_back(mk_row(100, 2, 100, 0));

    foreach (dir[i]) send_matrix(dir[i].m, dir[i].typed, dir[i].r);

    for (int i = 0; i < N_RND; i++) begin
      if (i == N_RND / 2) begin
        // drain everything before carrying on
        mat.valid <= 1'b0;
        @(posedge clk);
        while (pending_eigs.size() != 0) @(posedge clk);
      end
      m = rand_matrix();
      send_matrix(m, 1'b0, none);
    end
    mat.valid <= 1'b0;

    while (pending_eigs.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < 2 * LAT) begin
      @(posedge clk);
      wait_cnt++;
    end

    $display("tb: %0d matrices sent, %0d result words checked, %0d mismatches",
             words_in, words_out, err_cnt);
    $display("tb: covered zero off-diagonal, ties, extremes, back-pressure and drain");
    if (err_cnt == 0 && pending_eigs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/esym_pkg.sv
rtl/core/esym_if.sv
rtl/core/esym_sqrt.sv
rtl/core/esym_div.sv
rtl/core/symmetric_2x2_eigen_solver.sv
sim/symmetric_2x2_eigen_solver_test.sv
